// ===== rtl/sphere_triangle_subdivider_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider: assertion macros
// Concurrent assertion helpers clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_UNIT_ASSERT_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Shared state types, vector identifiers and the emission order table.
// ----------------------------------------------------------------------------
`default_nettype none

package stsd_pkg;

    localparam int NUM_RESULTS = 12;
    localparam int NUM_VECS    = 6;

    // The six distinct vectors of one subdivided triangle.
    typedef enum logic [2:0] {
        VID_V1,
        VID_V2,
        VID_V3,
        VID_M12,
        VID_M23,
        VID_M31
    } t_vec_id;

    typedef enum logic [2:0] {
        PR_IDLE,
        PR_SQUARE,
        PR_SQRT,
        PR_PREP,
        PR_DIV,
        PR_DONE
    } t_proj_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_WAIT,
        BK_HAND
    } t_back_state;

    // Emission order: (m31,v1,m12), (m12,v2,m23), (m23,v3,m31), (m12,m23,m31).
    function automatic t_vec_id seq_vec(input logic [3:0] idx);
        t_vec_id vid;
        unique case (idx)
            4'd0:    vid = VID_M31;
            4'd1:    vid = VID_V1;
            4'd2:    vid = VID_M12;
            4'd3:    vid = VID_M12;
            4'd4:    vid = VID_V2;
            4'd5:    vid = VID_M23;
            4'd6:    vid = VID_M23;
            4'd7:    vid = VID_V3;
            4'd8:    vid = VID_M31;
            4'd9:    vid = VID_M12;
            4'd10:   vid = VID_M23;
            default: vid = VID_M31;
        endcase
        return vid;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stsd_front.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider: front end
// Accepts triangles and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_front #(
    parameter int IN_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [9*IN_WIDTH-1:0]   i_tri,
    output logic                    o_valid,
    output logic [9*IN_WIDTH-1:0]   o_tri,
    input  logic                    i_take
);
    import stsd_pkg::*;

    logic [9*IN_WIDTH-1:0] r_slot [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_tri   = r_slot[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wp] <= i_tri;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stsd_proj.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider: projection unit
// Normalises one vector: sum of squares, bit-serial square root, then three
// restoring dividers in parallel giving the rounded unit components.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_proj #(
    parameter int MW = 25,
    parameter int F  = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [MW:0]  i_x,
    input  logic signed [MW:0]  i_y,
    input  logic signed [MW:0]  i_z,
    output logic                o_done,
    output logic signed [F+1:0] o_ux,
    output logic signed [F+1:0] o_uy,
    output logic signed [F+1:0] o_uz,
    output logic                o_zero
);
    import stsd_pkg::*;

    localparam int SW = 2*MW + 2;
    localparam int RW = MW + 1;
    localparam int DW = MW + F + 3;
    localparam int CW = $clog2(SW + 1);

    t_proj_state      r_state;
    t_proj_state      n_state;
    logic [MW-1:0]    r_mag [3];
    logic [2:0]       r_neg;
    logic [2*MW-1:0]  r_prod;
    logic [SW-1:0]    r_sum;
    logic [SW-1:0]    r_v;
    logic [SW-1:0]    r_r;
    logic [SW-1:0]    r_bit;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_rem [3];
    logic [DW-1:0]    r_den;
    logic [F:0]       r_q [3];
    logic             r_zero;

    logic [MW:0]      w_ax;
    logic [MW:0]      w_ay;
    logic [MW:0]      w_az;
    logic [MW-1:0]    w_sq_in;
    logic [SW-1:0]    w_trial;
    logic [RW-1:0]    w_root;
    logic [F+1:0]     w_pos [3];
    logic [F+1:0]     w_out [3];

    // Input magnitudes never exceed half the signed range, so MW bits hold them.
    assign w_ax = i_x[MW] ? (~i_x + 1'b1) : i_x;
    assign w_ay = i_y[MW] ? (~i_y + 1'b1) : i_y;
    assign w_az = i_z[MW] ? (~i_z + 1'b1) : i_z;

    assign w_sq_in = (r_cnt == CW'(0)) ? r_mag[0] :
                     (r_cnt == CW'(1)) ? r_mag[1] : r_mag[2];
    assign w_trial = r_r + r_bit;
    assign w_root  = r_r[RW-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pos[k] = (r_q[k] > (F+1)'(1 << F)) ? (F+2)'(1 << F) : {1'b0, r_q[k]};
            w_out[k] = r_neg[k] ? (~w_pos[k] + 1'b1) : w_pos[k];
        end
    end

    assign o_ux   = w_out[0];
    assign o_uy   = w_out[1];
    assign o_uz   = w_out[2];
    assign o_zero = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            PR_IDLE: begin
                if (i_start) begin
                    n_state = PR_SQUARE;
                end
            end
            PR_SQUARE: begin
                if (r_cnt == CW'(3)) begin
                    n_state = PR_SQRT;
                end
            end
            PR_SQRT: begin
                if (r_cnt == CW'(SW/2 - 1)) begin
                    n_state = PR_PREP;
                end
            end
            PR_PREP: begin
                n_state = (w_root == '0) ? PR_DONE : PR_DIV;
            end
            PR_DIV: begin
                if (r_cnt == CW'(F)) begin
                    n_state = PR_DONE;
                end
            end
            PR_DONE: begin
                o_done  = 1'b1;
                n_state = PR_IDLE;
            end
            default: n_state = PR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            PR_IDLE: begin
                if (i_start) begin
                    r_mag[0] <= w_ax[MW-1:0];
                    r_mag[1] <= w_ay[MW-1:0];
                    r_mag[2] <= w_az[MW-1:0];
                    r_neg    <= {i_z[MW], i_y[MW], i_x[MW]};
                    r_cnt    <= '0;
                    r_sum    <= '0;
                end
            end
            PR_SQUARE: begin
                r_prod <= w_sq_in * w_sq_in;
                if (r_cnt != CW'(0)) begin
                    r_sum <= r_sum + SW'(r_prod);
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(3)) begin
                    r_v   <= r_sum + SW'(r_prod);
                    r_r   <= '0;
                    r_bit <= SW'(1) << (SW - 2);
                    r_cnt <= '0;
                end
            end
            PR_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v <= r_v - w_trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            PR_PREP: begin
                r_zero <= (w_root == '0);
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= (DW'(r_mag[k]) << (F + 1)) + DW'(w_root);
                    r_q[k]   <= '0;
                end
                r_den <= DW'(w_root) << (F + 1);
                r_cnt <= '0;
            end
            PR_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_den) begin
                        r_rem[k] <= r_rem[k] - r_den;
                        r_q[k]   <= {r_q[k][F-1:0], 1'b1};
                    end else begin
                        r_q[k]   <= {r_q[k][F-1:0], 1'b0};
                    end
                end
                r_den <= r_den >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/stsd_back.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider: back end
// Runs the projection unit over the three vertices and three midpoints, then
// hands the six vectors to an output bank that emits the twelve results.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_back #(
    parameter int IN_WIDTH = 24,
    parameter int MW       = 25,
    parameter int F        = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [9*IN_WIDTH-1:0] i_tri,
    output logic                  o_take,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [F+1:0]   o_unit_x,
    output logic signed [F+1:0]   o_unit_y,
    output logic signed [F+1:0]   o_unit_z,
    output logic                  o_degenerate,
    output logic                  o_last_vertex
);
    import stsd_pkg::*;

    localparam int U = F + 2;

    t_back_state         r_state;
    t_back_state         n_state;
    t_vec_id             r_vid;
    logic [U-1:0]        r_rx [NUM_VECS];
    logic [U-1:0]        r_ry [NUM_VECS];
    logic [U-1:0]        r_rz [NUM_VECS];
    logic                r_rd [NUM_VECS];
    logic [U-1:0]        r_ox [NUM_VECS];
    logic [U-1:0]        r_oy [NUM_VECS];
    logic [U-1:0]        r_oz [NUM_VECS];
    logic                r_od [NUM_VECS];
    logic                r_out_valid;
    logic [3:0]          r_oidx;

    logic                w_start;
    logic signed [MW:0]  w_x;
    logic signed [MW:0]  w_y;
    logic signed [MW:0]  w_z;
    logic                w_done;
    logic signed [U-1:0] w_ux;
    logic signed [U-1:0] w_uy;
    logic signed [U-1:0] w_uz;
    logic                w_zero;
    t_vec_id             w_sel;

    function automatic logic signed [MW:0] ext_in(input logic [IN_WIDTH-1:0] v);
        return {{(MW + 1 - IN_WIDTH){v[IN_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [MW:0] mid(input logic [U-1:0] p, input logic [U-1:0] q);
        return {{(MW + 1 - U){p[U-1]}}, p} + {{(MW + 1 - U){q[U-1]}}, q};
    endfunction

    always_comb begin
        w_x = '0;
        w_y = '0;
        w_z = '0;
        unique case (r_vid)
            VID_V1: begin
                w_x = ext_in(i_tri[0*IN_WIDTH +: IN_WIDTH]);
                w_y = ext_in(i_tri[1*IN_WIDTH +: IN_WIDTH]);
                w_z = ext_in(i_tri[2*IN_WIDTH +: IN_WIDTH]);
            end
            VID_V2: begin
                w_x = ext_in(i_tri[3*IN_WIDTH +: IN_WIDTH]);
                w_y = ext_in(i_tri[4*IN_WIDTH +: IN_WIDTH]);
                w_z = ext_in(i_tri[5*IN_WIDTH +: IN_WIDTH]);
            end
            VID_V3: begin
                w_x = ext_in(i_tri[6*IN_WIDTH +: IN_WIDTH]);
                w_y = ext_in(i_tri[7*IN_WIDTH +: IN_WIDTH]);
                w_z = ext_in(i_tri[8*IN_WIDTH +: IN_WIDTH]);
            end
            VID_M12: begin
                w_x = mid(r_rx[0], r_rx[1]);
                w_y = mid(r_ry[0], r_ry[1]);
                w_z = mid(r_rz[0], r_rz[1]);
            end
            VID_M23: begin
                w_x = mid(r_rx[1], r_rx[2]);
                w_y = mid(r_ry[1], r_ry[2]);
                w_z = mid(r_rz[1], r_rz[2]);
            end
            VID_M31: begin
                w_x = mid(r_rx[2], r_rx[0]);
                w_y = mid(r_ry[2], r_ry[0]);
                w_z = mid(r_rz[2], r_rz[0]);
            end
            default: begin
            end
        endcase
    end

    stsd_proj #(
        .MW (MW),
        .F  (F)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_done  (w_done),
        .o_ux    (w_ux),
        .o_uy    (w_uy),
        .o_uz    (w_uz),
        .o_zero  (w_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        o_take  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    n_state = BK_START;
                end
            end
            BK_START: begin
                w_start = 1'b1;
                n_state = BK_WAIT;
            end
            BK_WAIT: begin
                if (w_done) begin
                    n_state = (r_vid == VID_M31) ? BK_HAND : BK_START;
                end
            end
            BK_HAND: begin
                if (!r_out_valid) begin
                    o_take  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE) begin
            r_vid <= VID_V1;
        end
        if ((r_state == BK_WAIT) && w_done) begin
            r_rx[r_vid] <= w_ux;
            r_ry[r_vid] <= w_uy;
            r_rz[r_vid] <= w_uz;
            r_rd[r_vid] <= w_zero;
            r_vid       <= t_vec_id'(r_vid + 3'd1);
        end
        if (o_take) begin
            r_ox <= r_rx;
            r_oy <= r_ry;
            r_oz <= r_rz;
            r_od <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_oidx      <= '0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                r_oidx      <= '0;
            end else if (i_pop && r_out_valid) begin
                if (o_last_vertex) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_oidx <= r_oidx + 1'b1;
                end
            end
        end
    end

    assign w_sel         = seq_vec(r_oidx);
    assign o_empty       = !r_out_valid;
    assign o_unit_x      = r_ox[w_sel];
    assign o_unit_y      = r_oy[w_sel];
    assign o_unit_z      = r_oz[w_sel];
    assign o_degenerate  = r_od[w_sel];
    assign o_last_vertex = (r_oidx == 4'(NUM_RESULTS - 1));

endmodule

`default_nettype wire

// ===== rtl/sphere_triangle_subdivider_unit.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider unit
// One step of midpoint subdivision of a triangle onto the unit sphere.
// ----------------------------------------------------------------------------
// A triangle of three signed Q8.16 vertices is requested with push while full
// is low. Each request produces twelve unit vectors in signed Q1.14, read out
// oldest first: a result is on the o_unit_* ports while empty is low and is
// taken with pop. The order is (m31,v1,m12), (m12,v2,m23), (m23,v3,m31),
// (m12,m23,m31); o_last_vertex marks the twelfth. A zero-length vector comes
// out as zero with o_degenerate set.
// A two-entry input queue feeds the back end, which runs one shared
// projection unit six times per triangle. Each projection forms the sum of
// squares, then runs the bit-serial square root and the one-bit-per-cycle
// dividers on MW-bit magnitudes, MW being the larger of IN_WIDTH and
// OUT_FRAC_BITS + 2; a zero-length vector skips the dividers. Once the bank
// is loaded, its results follow one per cycle while pop is held high.
// The twelve results sit in their own output bank, so the next triangle is
// worked on while the receiver stalls. A request stays in the queue until its
// results are handed to the bank, so full rises once two requests are queued.
// Reset empties the queue and the output bank.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_triangle_subdivider_unit_assert.svh"

module sphere_triangle_subdivider_unit #(
    parameter int IN_WIDTH      = 24,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [IN_WIDTH-1:0]    i_a_x,
    input  logic signed [IN_WIDTH-1:0]    i_a_y,
    input  logic signed [IN_WIDTH-1:0]    i_a_z,
    input  logic signed [IN_WIDTH-1:0]    i_b_x,
    input  logic signed [IN_WIDTH-1:0]    i_b_y,
    input  logic signed [IN_WIDTH-1:0]    i_b_z,
    input  logic signed [IN_WIDTH-1:0]    i_c_x,
    input  logic signed [IN_WIDTH-1:0]    i_c_y,
    input  logic signed [IN_WIDTH-1:0]    i_c_z,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [OUT_FRAC_BITS+1:0] o_unit_x,
    output logic signed [OUT_FRAC_BITS+1:0] o_unit_y,
    output logic signed [OUT_FRAC_BITS+1:0] o_unit_z,
    output logic                          o_degenerate,
    output logic                          o_last_vertex
);
    import stsd_pkg::*;

    // Magnitude width inside the projection unit: it must hold both an input
    // component and the sum of two unit components.
    localparam int MW = (IN_WIDTH > OUT_FRAC_BITS + 2) ? IN_WIDTH : OUT_FRAC_BITS + 2;

    logic [9*IN_WIDTH-1:0] w_tri_in;
    logic [9*IN_WIDTH-1:0] w_tri_q;
    logic                  w_q_valid;
    logic                  w_q_take;

    assign w_tri_in = {i_c_z, i_c_y, i_c_x, i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x};

    // The front end only buffers requests; all arithmetic is in the back end.
    stsd_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_tri   (w_tri_in),
        .o_valid (w_q_valid),
        .o_tri   (w_tri_q),
        .i_take  (w_q_take)
    );

    stsd_back #(
        .IN_WIDTH (IN_WIDTH),
        .MW       (MW),
        .F        (OUT_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_tri         (w_tri_q),
        .o_take        (w_q_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_unit_z      (o_unit_z),
        .o_degenerate  (o_degenerate),
        .o_last_vertex (o_last_vertex)
    );

    // Twelve results leave in one burst: only the twelfth may drain the bank.
    `STSD_ASSERT_NEXT(a_burst_continues, (!empty && pop && !o_last_vertex), (!empty), "result bank drained before the twelfth result")
    `STSD_ASSERT_NEXT(a_burst_ends, (!empty && pop && o_last_vertex), (empty), "result bank still occupied after the twelfth result")
    // A degenerate vector is always emitted as the zero vector.
    `STSD_ASSERT_NOW(a_degenerate_zero, (!empty && o_degenerate), ((o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0)), "degenerate result with non-zero components")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Sphere triangle subdivider testbench
// Sends directed and random triangles, then predicts the twelve unit vectors
// of each one and compares them, field by field, with what the unit returns.
// ----------------------------------------------------------------------------
`default_nettype none

typedef logic signed [23:0] coord_t;

typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic        degen;
    logic        last;
} sphere_pt_t;

typedef struct {
    longint c[3];
    bit     zero;
} unit_dir_t;

class subdiv_scoreboard;
    sphere_pt_t pending_pts[$];
    int         mismatches;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic unit_dir_t to_sphere(longint x, longint y, longint z);
        unit_dir_t       u;
        longint          src[3];
        longint unsigned mag[3];
        longint unsigned sumsq;
        longint unsigned r;
        longint unsigned q;
        src[0] = x;
        src[1] = y;
        src[2] = z;
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (src[k] < 0) ? -src[k] : src[k];
            sumsq += mag[k] * mag[k];
        end
        u.zero = (sumsq == 0);
        r = u.zero ? 0 : int_sqrt(sumsq);
        for (int k = 0; k < 3; k++) begin
            q = 0;
            if (!u.zero) begin
                q = (2 * mag[k] * (64'd1 << 14) + r) / (2 * r);
                if (q > (64'd1 << 14)) q = 64'd1 << 14;
            end
            u.c[k] = (src[k] < 0) ? -longint'(q) : longint'(q);
        end
        return u;
    endfunction

    function automatic unit_dir_t mid(unit_dir_t p, unit_dir_t q);
        return to_sphere(p.c[0] + q.c[0], p.c[1] + q.c[1], p.c[2] + q.c[2]);
    endfunction

    // Works out the twelve vectors of one accepted triangle.
    function void note_request(coord_t t[9]);
        unit_dir_t v[3];
        unit_dir_t m12, m23, m31;
        unit_dir_t order[12];
        sphere_pt_t p;
        for (int i = 0; i < 3; i++)
            v[i] = to_sphere(longint'(t[3*i]), longint'(t[3*i+1]), longint'(t[3*i+2]));
        m12 = mid(v[0], v[1]);
        m23 = mid(v[1], v[2]);
        m31 = mid(v[2], v[0]);
        order = '{m31, v[0], m12, m12, v[1], m23, m23, v[2], m31, m12, m23, m31};
        for (int i = 0; i < stsd_pkg::NUM_RESULTS; i++) begin
            p.ux    = order[i].c[0][15:0];
            p.uy    = order[i].c[1][15:0];
            p.uz    = order[i].c[2][15:0];
            p.degen = order[i].zero;
            p.last  = (i == stsd_pkg::NUM_RESULTS - 1);
            pending_pts.insert(pending_pts.size(), p);
        end
    endfunction

    function void check_result(sphere_pt_t got);
        sphere_pt_t want;
        if (pending_pts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected vector %h %h %h degen=%b last=%b",
                         got.ux, got.uy, got.uz, got.degen, got.last);
            return;
        end
        want = pending_pts.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Vector mismatch: expected %h %h %h d=%b l=%b, got %h %h %h d=%b l=%b",
                         want.ux, want.uy, want.uz, want.degen, want.last,
                         got.ux, got.uy, got.uz, got.degen, got.last);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        empty;
    logic        pop;
    coord_t      i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic signed [15:0] o_unit_x, o_unit_y, o_unit_z;
    logic        o_degenerate;
    logic        o_last_vertex;

    subdiv_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count;

    sphere_triangle_subdivider_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_a_x        (i_a_x),
        .i_a_y        (i_a_y),
        .i_a_z        (i_a_z),
        .i_b_x        (i_b_x),
        .i_b_y        (i_b_y),
        .i_b_z        (i_b_z),
        .i_c_x        (i_c_x),
        .i_c_y        (i_c_y),
        .i_c_z        (i_c_z),
        .empty        (empty),
        .pop          (pop),
        .o_unit_x     (o_unit_x),
        .o_unit_y     (o_unit_y),
        .o_unit_z     (o_unit_z),
        .o_degenerate (o_degenerate),
        .o_last_vertex(o_last_vertex)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every input starts at a known value; the receiver's pop is afterwards driven
    // only from the result process below.
    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
    end

    // The timeout: a run this long means the unit has stopped answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Results are sampled on the edge itself, so the values seen are those
    // that stood before it. The pop for the next cycle is then chosen once.
    always @(posedge i_clk) begin
        sphere_pt_t got;
        if (i_rst_n && pop && !empty) begin
            got.ux    = o_unit_x;
            got.uy    = o_unit_y;
            got.uz    = o_unit_z;
            got.degen = o_degenerate;
            got.last  = o_last_vertex;
            sb.check_result(got);
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Holds a request on the ports until the unit takes it, then notes it
    // and leaves push low for a random number of idle cycles.
    task automatic send_triangle(coord_t t[9]);
        push  <= 1'b1;
        i_a_x <= t[0]; i_a_y <= t[1]; i_a_z <= t[2];
        i_b_x <= t[3]; i_b_y <= t[4]; i_b_z <= t[5];
        i_c_x <= t[6]; i_c_y <= t[7]; i_c_z <= t[8];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(t);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(600) - 300);
            default: return coord_t'($urandom_range(65536 * 4) - 65536 * 2);
        endcase
    endfunction

    task automatic random_triangle();
        coord_t t[9];
        int     shape;
        int     mode;
        int     zv;
        shape = $urandom_range(9);
        mode  = $urandom_range(2);
        zv    = $urandom_range(2);
        foreach (t[i]) t[i] = rand_coord(mode);
        case (shape)
            0: for (int k = 0; k < 3; k++) t[3 + k] = -t[k];      // a and b opposite
            1: for (int k = 0; k < 3; k++) t[3 * zv + k] = '0;    // one zero vertex
            2: for (int k = 0; k < 3; k++) t[6 + k] = t[k];       // a and c alike
            default: ;
        endcase
        send_triangle(t);
    endtask

    localparam coord_t MAXC = 24'sh7FFFFF;
    localparam coord_t MINC = -24'sh800000;
    localparam coord_t ONE  = 24'sh010000;

    initial begin
        coord_t t[9];
        sb = new();
        cycle_count   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 80;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero triangle, extremes, axis vertices, opposite
        // vertices, a single zero vertex, tiny and mixed-sign values.
        t = '{default: '0};                                send_triangle(t);
        t = '{default: MAXC};                              send_triangle(t);
        t = '{default: MINC};                              send_triangle(t);
        t = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send_triangle(t);
        t = '{ONE, 0, 0, -ONE, 0, 0, 0, 0, -ONE};          send_triangle(t);
        t = '{0, 0, 0, ONE, ONE, 0, 0, ONE, ONE};          send_triangle(t);
        t = '{MAXC, MINC, MAXC, MINC, MAXC, MINC, 1, -1, 1}; send_triangle(t);
        t = '{1, 0, 0, 0, -1, 0, 0, 0, 1};                 send_triangle(t);
        t = '{MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 0, 0}; send_triangle(t);
        t = '{-1, -1, -1, 1, 1, 1, MAXC, 0, MINC};         send_triangle(t);
        t = '{3, 4, 0, 0, 3, 4, 4, 0, 3};                  send_triangle(t);
        t = '{MINC, 0, 0, 0, MINC, 0, 0, 0, MINC};         send_triangle(t);
        t = '{5, 0, 0, 5, 0, 0, 5, 0, 0};                  send_triangle(t);

        // Random part in three idling phases.
        for (int n = 0; n < 450; n++) begin
            if (n == 150) begin
                send_idle_pct = 80;
                recv_idle_pct = 26;
            end else if (n == 300) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_triangle();
        end
        push <= 1'b0;

        while (sb.pending_pts.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_pts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
